/* rtl/aopa_pkg.sv */
// Package for the Asian option path accumulator.
// Holds widths, register indexes, config/result structs and the exp2/log2 tables.
// No dependencies.
`default_nettype none
package aopa_pkg;

  localparam int unsigned DefMaxIntervals = 4096;
  localparam int unsigned LimW            = 17;
  localparam int unsigned CfgDataW        = 48;
  localparam int unsigned CfgIdxW         = 3;

  localparam logic [CfgIdxW-1:0] CFG_INITIAL_PRICE      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_LOG2_PRICE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRIKE             = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DRIFT_LOG2         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VOL_LOG2           = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL_COUNT     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RECIP_INTERVALS    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PAYOFF_SCALE       = 3'd7;

  typedef struct packed {
    logic [31:0] initial_price;
    logic [31:0] initial_log2_price;
    logic [31:0] strike;
    logic [31:0] drift_log2;
    logic [30:0] vol_log2;
    logic [12:0] interval_count;
    logic [31:0] recip_intervals;
    logic [47:0] payoff_scale;
  } cfg_t;

  typedef struct packed {
    logic [31:0] geom_put_value;
    logic [31:0] geom_call_value;
    logic [31:0] arith_put_value;
    logic [31:0] arith_call_value;
  } res_t;

  function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
    logic [17:0] v;
    case (idx)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] log2_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/aopa_in_if.sv */
// Input channel: one Gaussian sample per path step.
// Depends on nothing.
`default_nettype none
interface aopa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gaussian_sample;
  logic               last_path;
  modport source (output valid, gaussian_sample, last_path, input ready);
  modport sink   (input valid, gaussian_sample, last_path, output ready);
endinterface
`default_nettype wire

/* rtl/aopa_out_if.sv */
// Result channel: four discounted mean payoffs.
// Depends on nothing.
`default_nettype none
interface aopa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] geom_put_value;
  logic [31:0] geom_call_value;
  logic [31:0] arith_put_value;
  logic [31:0] arith_call_value;
  modport source (output valid, geom_put_value, geom_call_value, arith_put_value,
                  arith_call_value, input ready);
  modport sink   (input valid, geom_put_value, geom_call_value, arith_put_value,
                  arith_call_value, output ready);
endinterface
`default_nettype wire

/* rtl/aopa_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing.
`default_nettype none
module aopa_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

/* rtl/aopa_core.sv */
// Sequencer and datapath around the shared multiplier: price step, log2,
// path-end means, payoff totals and output scaling. Depends on aopa_pkg, aopa_mul.
`default_nettype none
module aopa_core
  import aopa_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = DefMaxIntervals
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               start,
  input  wire logic signed [15:0] sample,
  input  wire logic               last,
  input  wire logic               out_free,
  output logic                    idle,
  output logic                    res_push,
  output res_t                    res
);
  localparam int unsigned CW = $clog2(MAX_INTERVALS);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_VOL_MUL = 17'h00002,
    S_VOL_WB  = 17'h00004,
    S_XI_MUL  = 17'h00008,
    S_XI_WB   = 17'h00010,
    S_XP_MUL  = 17'h00020,
    S_XP_WB   = 17'h00040,
    S_LG_NORM = 17'h00080,
    S_LG_MUL  = 17'h00100,
    S_LG_WB   = 17'h00200,
    S_MS_LO   = 17'h00400,
    S_MS_HI   = 17'h00800,
    S_MS_ACC  = 17'h01000,
    S_TOT     = 17'h02000,
    S_SO_MUL  = 17'h04000,
    S_SO_ACC  = 17'h08000,
    S_EMIT    = 17'h10000
  } state_t;

  state_t             state_r;
  logic signed [15:0] sample_r;
  logic               last_r;
  logic [31:0]        cur_r;
  logic [47:0]        psum_r;
  logic [47:0]        lsum_r;
  logic [CW-1:0]      cnt_r;
  logic [63:0]        tot_r [4];
  logic [47:0]        e_r;
  logic [31:0]        ep_r;
  logic [17:0]        m_r;
  logic               geo_r;
  logic [47:0]        ms_src_r;
  logic               ms_neg_r;
  logic               ms_arith_r;
  logic [4:0]         k_r;
  logic [30:0]        frac_r;
  logic [31:0]        gmean_r;
  logic [31:0]        amean_r;
  logic [111:0]       acc_r;
  logic [1:0]         q_r;
  logic [1:0]         j_r;
  logic [31:0]        res_r [4];

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  p_r;
  logic [6:0]   acc_sh;
  logic [111:0] acc_sum;
  logic [31:0]  sx;
  logic [4:0]   k_det;
  logic [16:0]  lim;
  logic [CW-1:0] cnt_new;
  logic [47:0]  lval, lsum_new, vs, q48;
  logic [16:0]  l17;
  logic [5:0]   kk;
  logic [16:0]  abs_s;
  logic [48:0]  msq;
  logic [63:0]  t_sel;
  logic [31:0]  tp [4];

  aopa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));

  assign abs_s = sample_r[15] ? 17'(-{sample_r[15], sample_r}) : {1'b0, sample_r};
  assign t_sel = tot_r[j_r];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_VOL_MUL: begin
        mul_a = {1'b0, cfg.vol_log2};
        mul_b = {15'b0, abs_s};
      end
      S_XI_MUL: begin
        mul_a = {19'b0, 13'(exp2_tab({1'b0, e_r[23:20]} + 5'd1) -
                            exp2_tab({1'b0, e_r[23:20]}))};
        mul_b = {12'b0, e_r[19:0]};
      end
      S_XP_MUL: begin
        mul_a = ep_r;
        mul_b = {14'b0, m_r};
      end
      S_LG_MUL: begin
        mul_a = {19'b0, 13'(log2_tab({1'b0, frac_r[30:27]} + 5'd1) -
                            log2_tab({1'b0, frac_r[30:27]}))};
        mul_b = {5'b0, frac_r[26:0]};
      end
      S_MS_LO: begin
        mul_a = {8'b0, ms_src_r[23:0]};
        mul_b = cfg.recip_intervals;
      end
      S_MS_HI: begin
        mul_a = {8'b0, ms_src_r[47:24]};
        mul_b = cfg.recip_intervals;
      end
      S_SO_MUL: begin
        mul_a = q_r[1] ? t_sel[63:32] : t_sel[31:0];
        mul_b = q_r[0] ? {16'b0, cfg.payoff_scale[47:32]} : cfg.payoff_scale[31:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_r == S_MS_ACC) acc_sh = 7'd24;
    else begin
      case (q_r)
        2'd0:    acc_sh = 7'd0;
        2'd3:    acc_sh = 7'd64;
        default: acc_sh = 7'd32;
      endcase
    end
    acc_sum = acc_r + ({48'b0, p_r} << acc_sh);
  end

  // p * 2^e from the registered product, saturated to 32 bits
  always_comb begin
    logic [23:0] n;
    logic [24:0] sh, s;
    logic [49:0] prod, v;
    logic [81:0] wide;
    n    = e_r[47:24];
    sh   = {n[23], n} - 25'd16;
    s    = -sh;
    prod = p_r[49:0];
    wide = {32'b0, prod} << sh[4:0];
    v    = prod >> s[5:0];
    if (prod == '0) sx = '0;
    else if (!sh[24]) begin
      if (sh >= 25'd32 || wide[81:32] != '0) sx = '1;
      else sx = wide[31:0];
    end else begin
      if (s >= 25'd50) sx = '0;
      else if (v[49:32] != '0) sx = '1;
      else sx = v[31:0];
    end
  end

  always_comb begin
    k_det = '0;
    for (int i = 0; i < 32; i++) begin
      if (cur_r[i]) k_det = 5'(i);
    end
  end

  always_comb begin
    if (cfg.interval_count < 13'd2) lim = 17'd2;
    else if ({4'b0, cfg.interval_count} > LimW'(MAX_INTERVALS)) lim = LimW'(MAX_INTERVALS);
    else lim = {4'b0, cfg.interval_count};
    cnt_new  = cnt_r + 1'b1;
    kk       = {1'b0, k_r} - 6'd16;
    l17      = log2_tab({1'b0, frac_r[30:27]}) + {4'b0, p_r[39:27]};
    lval     = {{18{kk[5]}}, kk, 24'b0} + {23'b0, l17, 8'b0};
    lsum_new = lsum_r + lval;
    vs       = sample_r[15] ? -{1'b0, p_r[46:0]} : {1'b0, p_r[46:0]};
    msq      = acc_sum[79:31];
    q48      = msq[47:0];
  end

  always_comb begin
    tp[0] = (cfg.strike > gmean_r) ? cfg.strike - gmean_r : '0;
    tp[1] = (gmean_r > cfg.strike) ? gmean_r - cfg.strike : '0;
    tp[2] = (cfg.strike > amean_r) ? cfg.strike - amean_r : '0;
    tp[3] = (amean_r > cfg.strike) ? amean_r - cfg.strike : '0;
  end

  assign idle     = (state_r == S_IDLE);
  assign res_push = (state_r == S_EMIT) && out_free;
  assign res      = '{geom_put_value: res_r[0], geom_call_value: res_r[1],
                      arith_put_value: res_r[2], arith_call_value: res_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cur_r   <= '0;
      psum_r  <= '0;
      lsum_r  <= '0;
      for (int i = 0; i < 4; i++) tot_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            sample_r <= sample;
            last_r   <= last;
            if (cnt_r == '0) begin
              cur_r  <= (cfg.initial_price == '0) ? 32'd1 : cfg.initial_price;
              psum_r <= {16'b0, (cfg.initial_price == '0) ? 32'd1 : cfg.initial_price};
              lsum_r <= {{16{cfg.initial_log2_price[31]}}, cfg.initial_log2_price};
            end
            state_r <= S_VOL_MUL;
          end
        end
        S_VOL_MUL: state_r <= S_VOL_WB;
        S_VOL_WB: begin
          e_r     <= {{16{cfg.drift_log2[31]}}, cfg.drift_log2} +
                     {{12{vs[47]}}, vs[47:12]};
          ep_r    <= cur_r;
          geo_r   <= 1'b0;
          state_r <= S_XI_MUL;
        end
        S_XI_MUL: state_r <= S_XI_WB;
        S_XI_WB: begin
          m_r     <= exp2_tab({1'b0, e_r[23:20]}) + {5'b0, p_r[32:20]};
          state_r <= S_XP_MUL;
        end
        S_XP_MUL: state_r <= S_XP_WB;
        S_XP_WB: begin
          if (!geo_r) begin
            cur_r   <= (sx == '0) ? 32'd1 : sx;
            psum_r  <= psum_r + {16'b0, (sx == '0) ? 32'd1 : sx};
            state_r <= S_LG_NORM;
          end else begin
            gmean_r    <= sx;
            ms_src_r   <= psum_r;
            ms_neg_r   <= 1'b0;
            ms_arith_r <= 1'b1;
            state_r    <= S_MS_LO;
          end
        end
        S_LG_NORM: begin
          k_r     <= k_det;
          frac_r  <= 31'(cur_r << (5'd31 - k_det));
          state_r <= S_LG_MUL;
        end
        S_LG_MUL: state_r <= S_LG_WB;
        S_LG_WB: begin
          lsum_r <= lsum_new;
          if ({{(LimW-CW){1'b0}}, cnt_new} >= lim - 17'd1) begin
            cnt_r      <= '0;
            ms_src_r   <= lsum_new[47] ? -lsum_new : lsum_new;
            ms_neg_r   <= lsum_new[47];
            ms_arith_r <= 1'b0;
            state_r    <= S_MS_LO;
          end else begin
            cnt_r   <= cnt_new;
            state_r <= S_IDLE;
          end
        end
        S_MS_LO: state_r <= S_MS_HI;
        S_MS_HI: begin
          acc_r   <= {48'b0, p_r};
          state_r <= S_MS_ACC;
        end
        S_MS_ACC: begin
          if (!ms_arith_r) begin
            e_r     <= ms_neg_r ? -q48 : q48;
            ep_r    <= 32'd65536;
            geo_r   <= 1'b1;
            state_r <= S_XI_MUL;
          end else begin
            amean_r <= (msq[48:32] != '0) ? '1 : msq[31:0];
            state_r <= S_TOT;
          end
        end
        S_TOT: begin
          for (int i = 0; i < 4; i++) begin
            tot_r[i] <= ({1'b0, tot_r[i]} + {33'b0, tp[i]} > {1'b0, 64'hFFFF_FFFF_FFFF_FFFF})
                        ? '1 : tot_r[i] + {32'b0, tp[i]};
          end
          acc_r   <= '0;
          q_r     <= '0;
          j_r     <= '0;
          state_r <= last_r ? S_SO_MUL : S_IDLE;
        end
        S_SO_MUL: state_r <= S_SO_ACC;
        S_SO_ACC: begin
          if (q_r == 2'd3) begin
            res_r[j_r] <= (acc_sum[111:80] != '0) ? '1 : acc_sum[79:48];
            acc_r      <= '0;
            q_r        <= '0;
            j_r        <= j_r + 2'd1;
            state_r    <= (j_r == 2'd3) ? S_EMIT : S_SO_MUL;
          end else begin
            acc_r   <= acc_sum;
            q_r     <= q_r + 2'd1;
            state_r <= S_SO_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            for (int i = 0; i < 4; i++) tot_r[i] <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/asian_option_path_accumulator_unit.sv */
// Top level: configuration registers, core sequencer and output register.
// Depends on aopa_pkg, aopa_in_if, aopa_out_if, aopa_core.
//
//  channel   dir  fields                                       handshake
//  in_chan   in   gaussian_sample, last_path                   valid/ready
//  out_chan  out  geom/arith put/call values                   valid/ready
//  cfg_*     in   cfg_index, cfg_wdata                         cfg_we
//
// A step that does not end a path uses the shared multiplier four times in
// sequence. A path end adds the means and totals; the final path adds output
// scaling. Reset is synchronous; the result register frees the core while a
// request waits on out_chan, and the core holds only when a second result finds
// it still full.
`default_nettype none
module asian_option_path_accumulator_unit
  import aopa_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = DefMaxIntervals
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  aopa_in_if.sink                  in_chan,
  aopa_out_if.source               out_chan
);
  cfg_t cfg_r;
  logic out_valid_r;
  res_t out_r;
  logic core_idle, res_push, out_free;
  res_t core_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{initial_price: 32'd6553600, initial_log2_price: 32'd111465139,
                 strike: 32'd6553600, drift_log2: '0, vol_log2: '0,
                 interval_count: 13'd2, recip_intervals: 32'h4000_0000,
                 payoff_scale: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_PRICE:      cfg_r.initial_price      <= cfg_wdata[31:0];
        CFG_INITIAL_LOG2_PRICE: cfg_r.initial_log2_price <= cfg_wdata[31:0];
        CFG_STRIKE:             cfg_r.strike             <= cfg_wdata[31:0];
        CFG_DRIFT_LOG2:         cfg_r.drift_log2         <= cfg_wdata[31:0];
        CFG_VOL_LOG2:           cfg_r.vol_log2           <= cfg_wdata[30:0];
        CFG_INTERVAL_COUNT:     cfg_r.interval_count     <= cfg_wdata[12:0];
        CFG_RECIP_INTERVALS:    cfg_r.recip_intervals    <= cfg_wdata[31:0];
        CFG_PAYOFF_SCALE:       cfg_r.payoff_scale       <= cfg_wdata[47:0];
        default: begin
        end
      endcase
    end
  end

  assign in_chan.ready = core_idle;
  assign out_free      = !out_valid_r || out_chan.ready;

  aopa_core #(.MAX_INTERVALS(MAX_INTERVALS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (in_chan.valid && core_idle),
    .sample   (in_chan.gaussian_sample),
    .last     (in_chan.last_path),
    .out_free (out_free),
    .idle     (core_idle),
    .res_push (res_push),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_push || (out_valid_r && !out_chan.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) out_r <= core_res;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.geom_put_value   = out_r.geom_put_value;
  assign out_chan.geom_call_value  = out_r.geom_call_value;
  assign out_chan.arith_put_value  = out_r.arith_put_value;
  assign out_chan.arith_call_value = out_r.arith_call_value;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("core took a second request");

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!out_valid_r || out_chan.ready))
    else $error("result overwrote a pending one");

  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_push))
    else $error("result raised without a push");

endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for asian_option_path_accumulator_unit: drives sample requests,
// predicts the discounted put/call means in fixed point and compares every result.
// Depends on aopa_pkg, aopa_in_if, aopa_out_if and the RTL top level.
module testbench;
  import aopa_pkg::*;

  localparam int StallLimit = 4000;
  localparam int DrainCycles = 100;
  localparam int SettleCycles = 80;

  localparam longint unsigned Pow2Tab[17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
    96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
  localparam longint unsigned Log2Tab[17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  aopa_in_if  in_if();
  aopa_out_if out_if();

  asian_option_path_accumulator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirrored registers and path state
  logic [31:0] m_init_price, m_init_log2, m_strike, m_drift, m_recip;
  logic [30:0] m_vol;
  logic [12:0] m_count;
  logic [47:0] m_scale;
  logic [31:0] spot;
  int unsigned steps_taken;
  longint unsigned spot_sum;
  longint log2_sum;
  logic [63:0] gput_acc, gcall_acc, aput_acc, acall_acc;

  res_t payoff_q[$];
  int errors = 0;
  int samples_sent = 0;
  int payoffs_checked = 0;
  bit no_gaps;

  function automatic logic [31:0] pow2_scale(logic [31:0] p, longint e);
    longint ue, n, sh, s;
    logic [23:0] f;
    logic [3:0] idx;
    longint unsigned r, m, prod, v;
    ue = e + (longint'(1) <<< 48);
    n = (ue >>> 24) - (longint'(1) <<< 24);
    f = ue[23:0];
    idx = f[23:20];
    r = f[19:0];
    m = Pow2Tab[idx] + (((Pow2Tab[idx+1] - Pow2Tab[idx]) * r) >> 20);
    prod = longint'(p) * m;
    sh = n - 16;
    if (prod == 0) return 32'd0;
    if (sh >= 0) begin
      if (sh >= 32 || prod > (64'hFFFF_FFFF >> sh)) return 32'hFFFF_FFFF;
      return 32'(prod << sh);
    end
    s = -sh;
    if (s >= 64) return 32'd0;
    v = prod >> s;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  function automatic longint price_log2(logic [31:0] p);
    int k;
    logic [31:0] x;
    logic [3:0] idx;
    longint unsigned r, l;
    k = 31;
    while (k > 0 && !p[k]) k--;
    x = 32'(64'(p) << (31 - k));
    idx = x[30:27];
    r = x[26:0];
    l = Log2Tab[idx] + (((Log2Tab[idx+1] - Log2Tab[idx]) * r) >> 27);
    return longint'(k - 16) * 16777216 + longint'(l) * 256;
  endfunction

  function automatic longint unsigned mean_of(longint unsigned m, logic [31:0] r);
    logic [127:0] w;
    w = 128'(m) * 128'(r);
    return 64'(w >> 31);
  endfunction

  function automatic logic [31:0] discount(logic [63:0] t, logic [47:0] s);
    logic [127:0] w;
    w = (128'(t) * 128'(s)) >> 48;
    return (w > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [31:0] b);
    logic [64:0] t;
    t = 65'(a) + 65'(b);
    return t[64] ? 64'hFFFF_FFFF_FFFF_FFFF : t[63:0];
  endfunction

  function automatic void predict_step(logic signed [15:0] sample, logic last);
    int unsigned cnt;
    longint e, mlog;
    longint unsigned mag, amean_w;
    logic [31:0] gmean, amean;
    res_t r;
    cnt = m_count;
    if (cnt < 2) cnt = 2;
    if (cnt > DefMaxIntervals) cnt = DefMaxIntervals;
    if (steps_taken == 0) begin
      spot = (m_init_price != 0) ? m_init_price : 32'd1;
      spot_sum = spot;
      log2_sum = longint'($signed(m_init_log2));
    end
    e = longint'($signed(m_drift)) + ((longint'(m_vol) * longint'(sample)) >>> 12);
    spot = pow2_scale(spot, e);
    if (spot == 0) spot = 32'd1;
    spot_sum += spot;
    log2_sum += price_log2(spot);
    steps_taken++;
    if (steps_taken < cnt - 1) return;
    steps_taken = 0;
    mag = (log2_sum < 0) ? longint'(-log2_sum) : longint'(log2_sum);
    mlog = longint'(mean_of(mag, m_recip));
    if (log2_sum < 0) mlog = -mlog;
    gmean = pow2_scale(32'd65536, mlog);
    amean_w = mean_of(spot_sum, m_recip);
    amean = (amean_w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : amean_w[31:0];
    gput_acc  = sat_sum(gput_acc,  (m_strike > gmean) ? m_strike - gmean : 32'd0);
    gcall_acc = sat_sum(gcall_acc, (gmean > m_strike) ? gmean - m_strike : 32'd0);
    aput_acc  = sat_sum(aput_acc,  (m_strike > amean) ? m_strike - amean : 32'd0);
    acall_acc = sat_sum(acall_acc, (amean > m_strike) ? amean - m_strike : 32'd0);
    if (!last) return;
    r.geom_put_value   = discount(gput_acc, m_scale);
    r.geom_call_value  = discount(gcall_acc, m_scale);
    r.arith_put_value  = discount(aput_acc, m_scale);
    r.arith_call_value = discount(acall_acc, m_scale);
    payoff_q.push_back(r);
    gput_acc = '0;
    gcall_acc = '0;
    aput_acc = '0;
    acall_acc = '0;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INITIAL_PRICE:      m_init_price = value[31:0];
      CFG_INITIAL_LOG2_PRICE: m_init_log2 = value[31:0];
      CFG_STRIKE:             m_strike = value[31:0];
      CFG_DRIFT_LOG2:         m_drift = value[31:0];
      CFG_VOL_LOG2:           m_vol = value[30:0];
      CFG_INTERVAL_COUNT:     m_count = value[12:0];
      CFG_RECIP_INTERVALS:    m_recip = value[31:0];
      CFG_PAYOFF_SCALE:       m_scale = value[47:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] sample, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.gaussian_sample <= sample;
    in_if.last_path <= last;
    do @(posedge clk); while (!in_if.ready);
    predict_step(sample, last);
    samples_sent++;
  endtask

  // hold off until the core is idle so a register write cannot land mid-step
  task automatic settle();
    in_if.valid <= 1'b0;
    while (payoff_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_extremes();
    write_reg(CFG_PAYOFF_SCALE, 48'hFFFF_FFFF_FFFF);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    settle();
    write_reg(CFG_VOL_LOG2, 48'h7FFF_FFFF);
    write_reg(CFG_DRIFT_LOG2, 48'h7FFF_FFFF);
    write_reg(CFG_STRIKE, 48'hFFFF_FFFF);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    settle();
    write_reg(CFG_DRIFT_LOG2, 48'h8000_0000);
    write_reg(CFG_STRIKE, 48'd0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b1);
    settle();
    write_reg(CFG_INITIAL_PRICE, 48'd0);
    write_reg(CFG_VOL_LOG2, 48'd0);
    write_reg(CFG_DRIFT_LOG2, 48'd0);
    write_reg(CFG_STRIKE, 48'd6553600);
    write_reg(CFG_INTERVAL_COUNT, 48'd3);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd0, 1'b1);
    settle();
  endtask

  task automatic test_count_change();
    write_reg(CFG_INITIAL_PRICE, 48'd6553600);
    write_reg(CFG_VOL_LOG2, 48'd4000000);
    write_reg(CFG_INTERVAL_COUNT, 48'd4096);
    write_reg(CFG_RECIP_INTERVALS, 48'd524288);
    repeat (5) send_sample(16'($urandom), 1'b0);
    settle();
    write_reg(CFG_INTERVAL_COUNT, 48'd1);
    send_sample(16'($urandom), 1'b1);
    settle();
    write_reg(CFG_INTERVAL_COUNT, 48'd8191);
    repeat (2) send_sample(16'($urandom), 1'b1);
    settle();
    write_reg(CFG_INTERVAL_COUNT, 48'd0);
    send_sample(16'($urandom), 1'b1);
    settle();
  endtask

  task automatic test_random_paths(int phases, int per_phase);
    int cnt;
    bit wild;
    logic [31:0] p0;
    for (int ph = 0; ph < phases; ph++) begin
      wild = (ph % 3 == 2);
      no_gaps = (ph % 4 == 1);
      cnt = wild ? $urandom_range(0, 5) :
            ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 8);
      p0 = wild ? $urandom : $urandom_range(32'h1_0000, 32'hC8_0000);
      write_reg(CFG_INITIAL_PRICE, 48'(p0));
      write_reg(CFG_INITIAL_LOG2_PRICE, wild ? 48'($urandom) :
                48'(price_log2(p0 == 0 ? 32'd1 : p0)));
      write_reg(CFG_STRIKE, wild ? 48'($urandom) :
                48'(p0 + $urandom_range(0, 32'h20_0000) - 32'h10_0000));
      write_reg(CFG_DRIFT_LOG2, wild ? 48'($urandom) :
                48'($urandom_range(0, 32'h10_0000) - 32'h8_0000));
      write_reg(CFG_VOL_LOG2, wild ? 48'($urandom) : 48'($urandom_range(0, 32'h80_0000)));
      write_reg(CFG_INTERVAL_COUNT, 48'(cnt));
      write_reg(CFG_RECIP_INTERVALS, wild ? 48'($urandom_range(1, 32'h8000_0000)) :
                48'(32'h8000_0000 / ((cnt < 2) ? 2 : cnt)));
      write_reg(CFG_PAYOFF_SCALE, {16'($urandom), 32'($urandom)});
      for (int i = 0; i < per_phase; i++)
        send_sample(16'($urandom), $urandom_range(0, 9) < 4);
      settle();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.gaussian_sample <= '0;
    in_if.last_path <= 1'b0;
    m_init_price = 32'd6553600;
    m_init_log2 = 32'd111465139;
    m_strike = 32'd6553600;
    m_drift = '0;
    m_vol = '0;
    m_count = 13'd2;
    m_recip = 32'h4000_0000;
    m_scale = '0;
    spot = '0;
    steps_taken = 0;
    spot_sum = 0;
    log2_sum = 0;
    gput_acc = '0;
    gcall_acc = '0;
    aput_acc = '0;
    acall_acc = '0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_count_change();
    test_random_paths(7, 62);
    in_if.valid <= 1'b0;
    while (payoff_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d sample requests and %0d payoff results over extreme,",
             samples_sent, payoffs_checked);
    $display("count-change and random register settings.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    forever begin
      stall = $urandom_range(0, 16);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (payoff_q.size() == 0) begin
        $error("payoff result with no request pending");
        errors++;
      end else begin
        exp_r = payoff_q.pop_front();
        payoffs_checked++;
        if (out_if.geom_put_value !== exp_r.geom_put_value) begin
          $error("geom_put_value exp %0d got %0d", exp_r.geom_put_value,
                 out_if.geom_put_value);
          errors++;
        end
        if (out_if.geom_call_value !== exp_r.geom_call_value) begin
          $error("geom_call_value exp %0d got %0d", exp_r.geom_call_value,
                 out_if.geom_call_value);
          errors++;
        end
        if (out_if.arith_put_value !== exp_r.arith_put_value) begin
          $error("arith_put_value exp %0d got %0d", exp_r.arith_put_value,
                 out_if.arith_put_value);
          errors++;
        end
        if (out_if.arith_call_value !== exp_r.arith_call_value) begin
          $error("arith_call_value exp %0d got %0d", exp_r.arith_call_value,
                 out_if.arith_call_value);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
rtl/aopa_pkg.sv
rtl/aopa_in_if.sv
rtl/aopa_out_if.sv
rtl/aopa_mul.sv
rtl/aopa_core.sv
rtl/asian_option_path_accumulator_unit.sv
verif/testbench.sv
